FILE: rtl/core/dor_pkg.sv
// ----------------------------------------------------------------------------
// dor_pkg
// Shared constants, codes, types and helpers of the disk overlap relaxation
// block.
// ----------------------------------------------------------------------------
package dor_pkg;

   localparam int MAX_DISKS  = 256;
   localparam int SLOT_W     = $clog2(MAX_DISKS);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int FRAC_BITS  = 14;
   localparam int PAL_W      = 10;
   localparam int POS_W      = PAL_W + FRAC_BITS;
   localparam int VEL_W      = POS_W;
   localparam int RAD_W      = 8;
   localparam int DAMP_W     = 16;
   localparam int NUDGE_W    = 16;
   localparam int NUDGE_FRAC = 14;
   localparam int CMD_W      = 3;
   localparam int ST_W       = 2;
   localparam int SLOTIN_W   = 8;
   localparam int OVL_W      = 16;
   localparam int OUT_CNT_W  = 9;
   localparam int USE_W      = 9;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int OP_W       = 4;

   // commands
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RELAX  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DROP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // result status
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUDGE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_USE  = 3'd4;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
   localparam logic [OP_W-1:0] OP_APPEND   = 4'd2;
   localparam logic [OP_W-1:0] OP_DROP     = 4'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 4'd4;
   localparam logic [OP_W-1:0] OP_RD_ISSUE = 4'd5;
   localparam logic [OP_W-1:0] OP_RD_DONE  = 4'd6;
   localparam logic [OP_W-1:0] OP_I_READ   = 4'd7;
   localparam logic [OP_W-1:0] OP_I_DAMP   = 4'd8;
   localparam logic [OP_W-1:0] OP_I_REFL   = 4'd9;
   localparam logic [OP_W-1:0] OP_J_READ   = 4'd10;
   localparam logic [OP_W-1:0] OP_J_DIFF   = 4'd11;
   localparam logic [OP_W-1:0] OP_J_MUL    = 4'd12;
   localparam logic [OP_W-1:0] OP_J_EVAL   = 4'd13;
   localparam logic [OP_W-1:0] OP_I_WRITE  = 4'd14;
   localparam logic [OP_W-1:0] OP_RSP      = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CNT_W-1:0] k_idx;
      logic [CNT_W-1:0] m_idx;
   } dor_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] count;
   } dor_stat_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [RAD_W-1:0] r;
      logic [VEL_W-1:0] vx;
      logic [VEL_W-1:0] vy;
   } dor_disk_type;

   // saturating v + n or v - n, n non-negative
   function automatic logic [VEL_W-1:0] vel_add(logic [VEL_W-1:0] v, logic [VEL_W-1:0] n,
                                                logic sub);
      logic signed [VEL_W+1:0] a;
      logic signed [VEL_W+1:0] b;
      logic signed [VEL_W+1:0] s;
      logic [VEL_W-1:0] res;
      a = $signed({{2{v[VEL_W-1]}}, v});
      b = $signed({2'b00, n});
      s = sub ? (a - b) : (a + b);
      if (s > $signed({3'b000, {(VEL_W-1){1'b1}}})) begin
         res = {1'b0, {(VEL_W-1){1'b1}}};
      end else if (s < $signed({3'b111, {(VEL_W-1){1'b0}}})) begin
         res = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         res = s[VEL_W-1:0];
      end
      return res;
   endfunction

   // saturating negate
   function automatic logic [VEL_W-1:0] vel_neg(logic [VEL_W-1:0] v);
      logic [VEL_W-1:0] res;
      if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
         res = {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
         res = VEL_W'(0) - v;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/dor_ctrl.sv
// ----------------------------------------------------------------------------
// dor_ctrl
// Sequencer: request/response handshake, command decode and the two nested
// loops of a relaxation step.
// ----------------------------------------------------------------------------
module dor_ctrl import dor_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dor_stat_type stat,
   output dor_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_RD_WAIT = 4'd2;
   localparam logic [3:0] S_K_CHECK = 4'd3;
   localparam logic [3:0] S_I_DAMP  = 4'd4;
   localparam logic [3:0] S_I_REFL  = 4'd5;
   localparam logic [3:0] S_J_CHECK = 4'd6;
   localparam logic [3:0] S_J_DIFF  = 4'd7;
   localparam logic [3:0] S_J_MUL   = 4'd8;
   localparam logic [3:0] S_J_EVAL  = 4'd9;
   localparam logic [3:0] S_I_MOVE  = 4'd10;
   localparam logic [3:0] S_FINISH  = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] m_ff, m_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]  op;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      op           = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            unique case (stat.command)
               CMD_APPEND: begin
                  if (stat.status == ST_OK) op = OP_APPEND;
               end
               CMD_RELAX: begin
                  k_in     = '0;
                  state_in = S_K_CHECK;
               end
               CMD_DROP: begin
                  if (stat.status == ST_OK) op = OP_DROP;
               end
               CMD_READ: begin
                  if (stat.status == ST_OK) begin
                     op       = OP_RD_ISSUE;
                     state_in = S_RD_WAIT;
                  end
               end
               CMD_CLEAR: op = OP_CLEAR;
               default: ;
            endcase
         end
         S_RD_WAIT: begin
            op       = OP_RD_DONE;
            state_in = S_FINISH;
         end
         S_K_CHECK: begin
            if (k_ff == stat.count) begin
               state_in = S_FINISH;
            end else begin
               op       = OP_I_READ;
               state_in = S_I_DAMP;
            end
         end
         S_I_DAMP: begin
            op       = OP_I_DAMP;
            state_in = S_I_REFL;
         end
         S_I_REFL: begin
            op       = OP_I_REFL;
            m_in     = '0;
            state_in = S_J_CHECK;
         end
         S_J_CHECK: begin
            if (m_ff == stat.count) begin
               state_in = S_I_MOVE;
            end else if (m_ff == k_ff) begin
               m_in = m_ff + 1'b1;
            end else begin
               op       = OP_J_READ;
               state_in = S_J_DIFF;
            end
         end
         S_J_DIFF: begin
            op       = OP_J_DIFF;
            state_in = S_J_MUL;
         end
         S_J_MUL: begin
            op       = OP_J_MUL;
            state_in = S_J_EVAL;
         end
         S_J_EVAL: begin
            op       = OP_J_EVAL;
            m_in     = m_ff + 1'b1;
            state_in = S_J_CHECK;
         end
         S_I_MOVE: begin
            op       = OP_I_WRITE;
            k_in     = k_ff + 1'b1;
            state_in = S_K_CHECK;
         end
         S_FINISH: begin
            // result register frees up when the pending transaction leaves
            if (!rsp_valid_ff || rsp_ready) begin
               op           = OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         m_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd       = '{op: op, k_idx: k_ff, m_idx: m_ff};

endmodule

FILE: rtl/core/dor_dp.sv
// ----------------------------------------------------------------------------
// dor_dp
// Datapath: configuration registers, ring store of disks, per-disk and
// per-pair arithmetic, result register.
// ----------------------------------------------------------------------------
module dor_dp import dor_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dor_cmd_type          cmd,
   output dor_stat_type         stat,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [RAD_W-1:0]     req_radius,
   input  logic [SLOTIN_W-1:0]  req_read_slot,
   output logic [OVL_W-1:0]     rsp_overlap_count,
   output logic [POS_W-1:0]     rsp_read_x,
   output logic [POS_W-1:0]     rsp_read_y,
   output logic [RAD_W-1:0]     rsp_read_radius,
   output logic [OUT_CNT_W-1:0] rsp_count_now,
   output logic [ST_W-1:0]      rsp_status
);

   localparam int D2_W = 2 * POS_W + 1;
   localparam int SW   = POS_W + 2;

   // configuration
   logic [PAL_W-1:0]   palette_ff;
   logic [DAMP_W-1:0]  damping_ff;
   logic [NUDGE_W-1:0] nudge_ff;
   logic               mode_ff;
   logic [USE_W-1:0]   in_use_ff;

   // store bookkeeping
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;

   // captured request
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [POS_W-1:0]    px_ff, px_in, py_ff, py_in;
   logic [RAD_W-1:0]    pr_ff, pr_in;
   logic [SLOTIN_W-1:0] rslot_ff, rslot_in;
   logic [ST_W-1:0]     status_ff, status_in;

   // step state
   logic [OVL_W-1:0] pairs_ff, pairs_in;
   logic             any_ff, any_in;
   logic [POS_W-1:0] rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [RAD_W-1:0] rdr_ff, rdr_in;

   // visited disk
   logic [POS_W-1:0] xi_ff, xi_in, yi_ff, yi_in;
   logic [RAD_W-1:0] ri_ff, ri_in;
   logic [VEL_W-1:0] vxi_ff, vxi_in, vyi_ff, vyi_in;
   logic [VEL_W-1:0] dmx_ff, dmx_in, dmy_ff, dmy_in;
   logic             sgx_ff, sgx_in, sgy_ff, sgy_in;

   // pair test pipeline
   logic [POS_W-1:0]     adx_ff, adx_in, ady_ff, ady_in;
   logic [2*RAD_W+1:0]   rs2_ff, rs2_in;
   logic [2*POS_W-1:0]   sqx_ff, sqx_in, sqy_ff, sqy_in;

   // result register
   logic [OVL_W-1:0]     ro_ff, ro_in;
   logic [POS_W-1:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic [RAD_W-1:0]     rr_ff, rr_in;
   logic [OUT_CNT_W-1:0] rc_ff, rc_in;
   logic [ST_W-1:0]      rst_ff, rst_in;

   // disk store
   dor_disk_type      mem_ff [MAX_DISKS];
   dor_disk_type      rd_ff;
   logic              mem_we, mem_re;
   logic [SLOT_W-1:0] mem_wa, mem_ra;
   dor_disk_type      mem_wd;

   // helpers
   logic [SLOT_W-1:0]       slot_i, slot_j;
   logic [15:0]             cnt16, lim16;
   logic [ST_W-1:0]         acc_status;
   logic [VEL_W-1:0]        magx, magy;
   logic [VEL_W+DAMP_W-1:0] prodx, prody;
   logic [VEL_W-1:0]        dvx, dvy;
   logic signed [SW-1:0]    pal_s, rad_s, pmr_s, xs, ys, cx1, cy1, cx, cy;
   logic                    wall_x, wall_y;
   logic signed [POS_W:0]   dx, dy;
   logic [RAD_W:0]          rsum;
   logic [D2_W-1:0]         d2, lim2;
   logic                    overlap, xlt, ylt;
   logic [NUDGE_W+FRAC_BITS-1:0] nudge_wide;
   logic [VEL_W-1:0]        nudge;
   logic signed [SW-1:0]    nx, ny;
   logic [POS_W-1:0]        mx, my;
   logic                    moving;

   assign slot_i = oldest_ff + cmd.k_idx[SLOT_W-1:0];
   assign slot_j = oldest_ff + cmd.m_idx[SLOT_W-1:0];

   // status decided against the store as it stands at acceptance
   assign cnt16 = 16'(count_ff);
   assign lim16 = (16'(in_use_ff) > 16'(MAX_DISKS)) ? 16'(MAX_DISKS) : 16'(in_use_ff);
   always_comb begin
      acc_status = ST_OK;
      case (req_command)
         CMD_APPEND: if (cnt16 >= lim16) acc_status = ST_FULL;
         CMD_DROP:   if (cnt16 == 16'd0) acc_status = ST_EMPTY;
         CMD_READ: begin
            if (cnt16 == 16'd0) acc_status = ST_EMPTY;
            else if (16'(req_read_slot) >= cnt16) acc_status = ST_RANGE;
         end
         default: ;
      endcase
   end

   // damping: magnitude times Q0.16, truncated, sign restored later
   assign magx  = rd_ff.vx[VEL_W-1] ? (VEL_W'(0) - rd_ff.vx) : rd_ff.vx;
   assign magy  = rd_ff.vy[VEL_W-1] ? (VEL_W'(0) - rd_ff.vy) : rd_ff.vy;
   assign prodx = (VEL_W+DAMP_W)'(magx) * (VEL_W+DAMP_W)'(damping_ff);
   assign prody = (VEL_W+DAMP_W)'(magy) * (VEL_W+DAMP_W)'(damping_ff);
   assign dvx   = sgx_ff ? (VEL_W'(0) - dmx_ff) : dmx_ff;
   assign dvy   = sgy_ff ? (VEL_W'(0) - dmy_ff) : dmy_ff;

   // walls, signed so a radius wider than the palette still clamps to r
   assign pal_s  = $signed({2'b00, palette_ff, {FRAC_BITS{1'b0}}});
   assign rad_s  = $signed(SW'({ri_ff, {FRAC_BITS{1'b0}}}));
   assign pmr_s  = pal_s - rad_s;
   assign xs     = $signed({2'b00, xi_ff});
   assign ys     = $signed({2'b00, yi_ff});
   assign wall_x = (xs > pmr_s) || (xs < rad_s);
   assign wall_y = (ys > pmr_s) || (ys < rad_s);
   assign cx1    = (xs > pmr_s) ? pmr_s : xs;
   assign cx     = (cx1 < rad_s) ? rad_s : cx1;
   assign cy1    = (ys > pmr_s) ? pmr_s : ys;
   assign cy     = (cy1 < rad_s) ? rad_s : cy1;

   // pair test
   assign dx      = $signed({1'b0, xi_ff}) - $signed({1'b0, rd_ff.x});
   assign dy      = $signed({1'b0, yi_ff}) - $signed({1'b0, rd_ff.y});
   assign rsum    = {1'b0, ri_ff} + {1'b0, rd_ff.r};
   assign d2      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign lim2    = D2_W'({rs2_ff, {(2*FRAC_BITS){1'b0}}});
   assign overlap = d2 < lim2;
   assign xlt     = xi_ff < rd_ff.x;
   assign ylt     = yi_ff < rd_ff.y;

   assign nudge_wide = {nudge_ff, {FRAC_BITS{1'b0}}} >> NUDGE_FRAC;
   assign nudge      = VEL_W'(nudge_wide);

   // move with position saturation
   assign nx     = xs + $signed({{2{vxi_ff[VEL_W-1]}}, vxi_ff});
   assign ny     = ys + $signed({{2{vyi_ff[VEL_W-1]}}, vyi_ff});
   assign mx     = nx[SW-1] ? '0 : (nx[POS_W] ? '1 : nx[POS_W-1:0]);
   assign my     = ny[SW-1] ? '0 : (ny[POS_W] ? '1 : ny[POS_W-1:0]);
   assign moving = !mode_ff || any_ff;

   always_comb begin
      count_in  = count_ff;   oldest_in = oldest_ff;
      cmd_in    = cmd_ff;     px_in     = px_ff;     py_in  = py_ff;
      pr_in     = pr_ff;      rslot_in  = rslot_ff;  status_in = status_ff;
      pairs_in  = pairs_ff;   any_in    = any_ff;
      rdx_in    = rdx_ff;     rdy_in    = rdy_ff;    rdr_in = rdr_ff;
      xi_in     = xi_ff;      yi_in     = yi_ff;     ri_in  = ri_ff;
      vxi_in    = vxi_ff;     vyi_in    = vyi_ff;
      dmx_in    = dmx_ff;     dmy_in    = dmy_ff;
      sgx_in    = sgx_ff;     sgy_in    = sgy_ff;
      adx_in    = adx_ff;     ady_in    = ady_ff;    rs2_in = rs2_ff;
      sqx_in    = sqx_ff;     sqy_in    = sqy_ff;
      ro_in     = ro_ff;      rx_in     = rx_ff;     ry_in  = ry_ff;
      rr_in     = rr_ff;      rc_in     = rc_ff;     rst_in = rst_ff;
      mem_we    = 1'b0;       mem_wa    = slot_i;    mem_wd = rd_ff;
      mem_re    = 1'b0;       mem_ra    = slot_i;
      unique case (cmd.op)
         OP_NONE: ;
         OP_ACCEPT: begin
            cmd_in    = req_command;
            px_in     = req_pos_x;
            py_in     = req_pos_y;
            pr_in     = req_radius;
            rslot_in  = req_read_slot;
            status_in = acc_status;
            pairs_in  = '0;
            any_in    = 1'b0;
            rdx_in    = '0;
            rdy_in    = '0;
            rdr_in    = '0;
         end
         OP_APPEND: begin
            mem_we   = 1'b1;
            mem_wa   = oldest_ff + count_ff[SLOT_W-1:0];
            mem_wd   = '{x: px_ff, y: py_ff, r: pr_ff, vx: '0, vy: '0};
            count_in = count_ff + 1'b1;
         end
         OP_DROP: begin
            oldest_in = oldest_ff + 1'b1;
            count_in  = count_ff - 1'b1;
         end
         OP_CLEAR: begin
            oldest_in = '0;
            count_in  = '0;
         end
         OP_RD_ISSUE: begin
            mem_re = 1'b1;
            mem_ra = oldest_ff + SLOT_W'(rslot_ff);
         end
         OP_RD_DONE: begin
            rdx_in = rd_ff.x;
            rdy_in = rd_ff.y;
            rdr_in = rd_ff.r;
         end
         OP_I_READ: begin
            mem_re = 1'b1;
            mem_ra = slot_i;
         end
         OP_I_DAMP: begin
            xi_in  = rd_ff.x;
            yi_in  = rd_ff.y;
            ri_in  = rd_ff.r;
            dmx_in = prodx[VEL_W+DAMP_W-1:DAMP_W];
            dmy_in = prody[VEL_W+DAMP_W-1:DAMP_W];
            sgx_in = rd_ff.vx[VEL_W-1];
            sgy_in = rd_ff.vy[VEL_W-1];
         end
         OP_I_REFL: begin
            vxi_in = wall_x ? vel_neg(dvx) : dvx;
            vyi_in = wall_y ? vel_neg(dvy) : dvy;
         end
         OP_J_READ: begin
            mem_re = 1'b1;
            mem_ra = slot_j;
         end
         OP_J_DIFF: begin
            adx_in = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
            ady_in = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
            rs2_in = rsum * rsum;
         end
         OP_J_MUL: begin
            sqx_in = (2*POS_W)'(adx_ff) * (2*POS_W)'(adx_ff);
            sqy_in = (2*POS_W)'(ady_ff) * (2*POS_W)'(ady_ff);
         end
         OP_J_EVAL: begin
            if (overlap) begin
               any_in   = 1'b1;
               pairs_in = (pairs_ff == '1) ? pairs_ff : pairs_ff + 1'b1;
               vxi_in   = vel_add(vxi_ff, nudge, xlt);
               vyi_in   = vel_add(vyi_ff, nudge, ylt);
               mem_we   = 1'b1;
               mem_wa   = slot_j;
               mem_wd   = rd_ff;
               mem_wd.vx = vel_add(rd_ff.vx, nudge, !xlt);
               mem_wd.vy = vel_add(rd_ff.vy, nudge, !ylt);
               xi_in    = cx[POS_W-1:0];
               yi_in    = cy[POS_W-1:0];
            end
         end
         OP_I_WRITE: begin
            mem_we = 1'b1;
            mem_wa = slot_i;
            mem_wd = '{x: moving ? mx : xi_ff, y: moving ? my : yi_ff, r: ri_ff,
                       vx: vxi_ff, vy: vyi_ff};
         end
         OP_RSP: begin
            ro_in  = (cmd_ff == CMD_RELAX) ? pairs_ff : '0;
            rx_in  = rdx_ff;
            ry_in  = rdy_ff;
            rr_in  = rdr_ff;
            rc_in  = OUT_CNT_W'(count_ff);
            rst_in = status_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= PAL_W'(775);
         damping_ff <= DAMP_W'(62259);
         nudge_ff   <= NUDGE_W'(819);
         mode_ff    <= 1'b1;
         in_use_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PALETTE: palette_ff <= csr_wdata[PAL_W-1:0];
            CSR_DAMPING: damping_ff <= csr_wdata[DAMP_W-1:0];
            CSR_NUDGE:   nudge_ff   <= csr_wdata[NUDGE_W-1:0];
            CSR_MODE:    mode_ff    <= csr_wdata[0];
            CSR_IN_USE:  in_use_ff  <= csr_wdata[USE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         oldest_ff <= '0;
      end else begin
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;   px_ff <= px_in;   py_ff <= py_in;   pr_ff <= pr_in;
      rslot_ff <= rslot_in;   status_ff <= status_in;
      pairs_ff <= pairs_in;   any_ff <= any_in;
      rdx_ff <= rdx_in;   rdy_ff <= rdy_in;   rdr_ff <= rdr_in;
      xi_ff <= xi_in;     yi_ff <= yi_in;     ri_ff <= ri_in;
      vxi_ff <= vxi_in;   vyi_ff <= vyi_in;
      dmx_ff <= dmx_in;   dmy_ff <= dmy_in;   sgx_ff <= sgx_in;   sgy_ff <= sgy_in;
      adx_ff <= adx_in;   ady_ff <= ady_in;   rs2_ff <= rs2_in;
      sqx_ff <= sqx_in;   sqy_ff <= sqy_in;
      ro_ff <= ro_in;     rx_ff <= rx_in;     ry_ff <= ry_in;
      rr_ff <= rr_in;     rc_ff <= rc_in;     rst_ff <= rst_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_ff <= mem_ff[mem_ra];
   end

   assign stat = '{command: cmd_ff, status: status_ff, count: count_ff};

   assign rsp_overlap_count = ro_ff;
   assign rsp_read_x        = rx_ff;
   assign rsp_read_y        = ry_ff;
   assign rsp_read_radius   = rr_ff;
   assign rsp_count_now     = rc_ff;
   assign rsp_status        = rst_ff;

endmodule

FILE: rtl/core/disk_overlap_relaxation.sv
// ----------------------------------------------------------------------------
// disk_overlap_relaxation
// Ring store of up to 256 disks with an overlap relaxation step.
// ----------------------------------------------------------------------------
// One command is handled at a time. Append, drop, clear and unknown commands
// go from decode straight to the result, a read in range through a wait state
// for the store read first. The input side opens again as the result is
// loaded. In a relax step over the stored disks, every ordered pair goes
// through one read of the disk store, a difference stage, a squaring stage
// and a compare and update stage, and each disk adds a read, a damping
// multiply, a wall check, a self-pair skip, a loop-end check and a write-back.
// A finished result waits in an output register, and the next transaction is
// taken in the meantime; a result that is still waiting when the next one
// finishes holds that one back until it is taken. No clearing pass after reset.
module disk_overlap_relaxation import dor_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [POS_W-1:0]     req_pos_x,
   input  logic [POS_W-1:0]     req_pos_y,
   input  logic [RAD_W-1:0]     req_radius,
   input  logic [SLOTIN_W-1:0]  req_read_slot,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OVL_W-1:0]     rsp_overlap_count,
   output logic [POS_W-1:0]     rsp_read_x,
   output logic [POS_W-1:0]     rsp_read_y,
   output logic [RAD_W-1:0]     rsp_read_radius,
   output logic [OUT_CNT_W-1:0] rsp_count_now,
   output logic [ST_W-1:0]      rsp_status,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   dor_cmd_type  cmd;
   dor_stat_type stat;

   dor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dor_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_command       (req_command),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_radius        (req_radius),
      .req_read_slot     (req_read_slot),
      .rsp_overlap_count (rsp_overlap_count),
      .rsp_read_x        (rsp_read_x),
      .rsp_read_y        (rsp_read_y),
      .rsp_read_radius   (rsp_read_radius),
      .rsp_count_now     (rsp_count_now),
      .rsp_status        (rsp_status)
   );

   // store never holds more disks than it has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(stat.count) <= 32'(MAX_DISKS))
      else $error("disk count above store depth");

   // a refused read returns no disk data
   a_refused_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_EMPTY))
      |-> (rsp_read_x == '0 && rsp_read_y == '0 && rsp_read_radius == '0))
      else $error("refused read carries data");

   // overlaps need at least two disks
   a_overlap_needs_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overlap_count != '0) |-> (rsp_count_now >= OUT_CNT_W'(2)))
      else $error("overlap counted with fewer than two disks");

   // one transaction in flight: accepting closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

endmodule

FILE: tb/tb_disk_overlap_relaxation.sv
// ----------------------------------------------------------------------------
// tb_disk_overlap_relaxation
// Self-checking bench: directed tables then random commands, each result checked
// against its table row or an in-bench model of the disk store and relax step.
// ----------------------------------------------------------------------------
module tb_disk_overlap_relaxation import dor_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   localparam longint POS_TOP = (longint'(1) << POS_W) - 1;
   localparam longint VEL_TOP = (longint'(1) << (VEL_W - 1)) - 1;
   localparam longint VEL_BOT = -(longint'(1) << (VEL_W - 1));

   typedef struct {
      logic [OVL_W-1:0]     ovl;
      logic [POS_W-1:0]     rx;
      logic [POS_W-1:0]     ry;
      logic [RAD_W-1:0]     rr;
      logic [OUT_CNT_W-1:0] cnt;
      logic [ST_W-1:0]      st;
   } disk_rsp_type;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [POS_W-1:0]    x;
      logic [POS_W-1:0]    y;
      logic [RAD_W-1:0]    r;
      logic [SLOTIN_W-1:0] slot;
      bit                  typed;
      disk_rsp_type        res;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command = '0;
   logic [POS_W-1:0]     req_pos_x = '0;
   logic [POS_W-1:0]     req_pos_y = '0;
   logic [RAD_W-1:0]     req_radius = '0;
   logic [SLOTIN_W-1:0]  req_read_slot = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OVL_W-1:0]     rsp_overlap_count;
   logic [POS_W-1:0]     rsp_read_x;
   logic [POS_W-1:0]     rsp_read_y;
   logic [RAD_W-1:0]     rsp_read_radius;
   logic [OUT_CNT_W-1:0] rsp_count_now;
   logic [ST_W-1:0]      rsp_status;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   disk_overlap_relaxation i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   logic [POS_W-1:0] m_x [MAX_DISKS];
   logic [POS_W-1:0] m_y [MAX_DISKS];
   logic [RAD_W-1:0] m_r [MAX_DISKS];
   longint           m_vx [MAX_DISKS];
   longint           m_vy [MAX_DISKS];
   int               m_oldest;
   int               m_count;
   longint           cfg_palette = 775;
   longint           cfg_damping = 62259;
   longint           cfg_nudge = 819;
   bit               cfg_mode = 1'b1;
   int               cfg_in_use = 0;

   disk_rsp_type pending_rsp [$];
   int           err_cnt = 0;
   int           cycle_cnt = 0;
   bit           calm = 1'b0;

   function automatic longint sat_vel(longint v);
      if (v > VEL_TOP) return VEL_TOP;
      if (v < VEL_BOT) return VEL_BOT;
      return v;
   endfunction

   function automatic longint damp_vel(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m * cfg_damping) >>> 16;
      return (v < 0) ? -m : m;
   endfunction

   function automatic int ring_slot(int k);
      return (m_oldest + k) % MAX_DISKS;
   endfunction

   function automatic bit disks_touch(int a, int b);
      longint dx, dy, rs;
      dx = longint'(m_x[a]) - longint'(m_x[b]);
      dy = longint'(m_y[a]) - longint'(m_y[b]);
      rs = (longint'(m_r[a]) + longint'(m_r[b])) << FRAC_BITS;
      return (dx * dx + dy * dy) < rs * rs;
   endfunction

   function automatic logic [OVL_W-1:0] relax_pass();
      longint pal, r, x, y, nud;
      int     pairs, i, j;
      bit     any;
      nud = cfg_nudge;   // Q2.14 to Q.14 is identity
      pal = cfg_palette << FRAC_BITS;
      pairs = 0;
      any = 1'b0;
      for (int k = 0; k < m_count; k++) begin
         i = ring_slot(k);
         r = longint'(m_r[i]) << FRAC_BITS;
         m_vx[i] = damp_vel(m_vx[i]);
         m_vy[i] = damp_vel(m_vy[i]);
         x = m_x[i];
         y = m_y[i];
         if (x > pal - r || x < r) m_vx[i] = sat_vel(-m_vx[i]);
         if (y > pal - r || y < r) m_vy[i] = sat_vel(-m_vy[i]);
         for (int n = 0; n < m_count; n++) begin
            j = ring_slot(n);
            if (j != i && disks_touch(i, j)) begin
               any = 1'b1;
               if (pairs < 65535) pairs++;
               if (m_x[i] < m_x[j]) begin
                  m_vx[i] = sat_vel(m_vx[i] - nud);
                  m_vx[j] = sat_vel(m_vx[j] + nud);
               end else begin
                  m_vx[i] = sat_vel(m_vx[i] + nud);
                  m_vx[j] = sat_vel(m_vx[j] - nud);
               end
               if (m_y[i] < m_y[j]) begin
                  m_vy[i] = sat_vel(m_vy[i] - nud);
                  m_vy[j] = sat_vel(m_vy[j] + nud);
               end else begin
                  m_vy[i] = sat_vel(m_vy[i] + nud);
                  m_vy[j] = sat_vel(m_vy[j] - nud);
               end
               x = m_x[i];
               y = m_y[i];
               if (x > pal - r) x = pal - r;
               if (x < r) x = r;
               if (y > pal - r) y = pal - r;
               if (y < r) y = r;
               m_x[i] = x[POS_W-1:0];
               m_y[i] = y[POS_W-1:0];
            end
         end
         if (!cfg_mode || any) begin
            x = longint'(m_x[i]) + m_vx[i];
            y = longint'(m_y[i]) + m_vy[i];
            if (x < 0) x = 0;
            if (x > POS_TOP) x = POS_TOP;
            if (y < 0) y = 0;
            if (y > POS_TOP) y = POS_TOP;
            m_x[i] = x[POS_W-1:0];
            m_y[i] = y[POS_W-1:0];
         end
      end
      return pairs[OVL_W-1:0];
   endfunction

   function automatic disk_rsp_type run_command(stim_row_type t);
      disk_rsp_type res;
      int           s, lim;
      res = '{default: '0};
      lim = (cfg_in_use > MAX_DISKS) ? MAX_DISKS : cfg_in_use;
      case (t.cmd)
         CMD_APPEND: begin
            if (m_count >= lim) begin
               res.st = ST_FULL;
            end else begin
               s = ring_slot(m_count);
               m_x[s] = t.x;
               m_y[s] = t.y;
               m_r[s] = t.r;
               m_vx[s] = 0;
               m_vy[s] = 0;
               m_count++;
            end
         end
         CMD_RELAX: res.ovl = relax_pass();
         CMD_DROP: begin
            if (m_count == 0) begin
               res.st = ST_EMPTY;
            end else begin
               m_oldest = ring_slot(1);
               m_count--;
            end
         end
         CMD_READ: begin
            if (m_count == 0) begin
               res.st = ST_EMPTY;
            end else if (int'(t.slot) >= m_count) begin
               res.st = ST_RANGE;
            end else begin
               s = ring_slot(t.slot);
               res.rx = m_x[s];
               res.ry = m_y[s];
               res.rr = m_r[s];
            end
         end
         CMD_CLEAR: begin
            m_oldest = 0;
            m_count = 0;
         end
         default: ;
      endcase
      res.cnt = m_count[OUT_CNT_W-1:0];
      return res;
   endfunction

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_item(stim_row_type t);
      disk_rsp_type p;
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= t.cmd;
      req_pos_x <= t.x;
      req_pos_y <= t.y;
      req_radius <= t.r;
      req_read_slot <= t.slot;
      do @(posedge clock); while (!req_ready);
      p = run_command(t);
      pending_rsp.push_back(t.typed ? t.res : p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_PALETTE: cfg_palette = val & 'h3FF;
         CSR_DAMPING: cfg_damping = val & 'hFFFF;
         CSR_NUDGE:   cfg_nudge = val & 'hFFFF;
         CSR_MODE:    cfg_mode = val[0];
         CSR_IN_USE:  cfg_in_use = val & 'h1FF;
         default: ;
      endcase
   endtask

   // result side
   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      disk_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result transaction with nothing expected");
            err_cnt++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_overlap_count !== e.ovl) begin
               $error("overlap_count exp %0d got %0d", e.ovl, rsp_overlap_count);
               err_cnt++;
            end
            if (rsp_read_x !== e.rx) begin
               $error("read_x exp %0h got %0h", e.rx, rsp_read_x);
               err_cnt++;
            end
            if (rsp_read_y !== e.ry) begin
               $error("read_y exp %0h got %0h", e.ry, rsp_read_y);
               err_cnt++;
            end
            if (rsp_read_radius !== e.rr) begin
               $error("read_radius exp %0d got %0d", e.rr, rsp_read_radius);
               err_cnt++;
            end
            if (rsp_count_now !== e.cnt) begin
               $error("count_now exp %0d got %0d", e.cnt, rsp_count_now);
               err_cnt++;
            end
            if (rsp_status !== e.st) begin
               $error("status exp %0d got %0d", e.st, rsp_status);
               err_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   localparam logic [POS_W-1:0] P_MAX = '1;
   localparam logic [POS_W-1:0] P_MID = 24'd1638400;   // 100.0
   localparam logic [POS_W-1:0] P_NEAR = 24'd1802240;  // 110.0
   localparam logic [CMD_W-1:0] CMD_BAD5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;

   // reset configuration, store limit 0
   stim_row_type empty_tab [] = '{
      '{CMD_READ,   0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_EMPTY}},
      '{CMD_DROP,   0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_EMPTY}},
      '{CMD_RELAX,  0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_OK}},
      '{CMD_APPEND, 5, 5, 9, 0, 1, '{0, 0, 0, 0, 0, ST_FULL}},
      '{CMD_BAD5,   0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_OK}},
      '{CMD_BAD7,   P_MAX, P_MAX, 255, 255, 1, '{0, 0, 0, 0, 0, ST_OK}}
   };

   // store limit 6
   stim_row_type fill_tab [] = '{
      '{CMD_APPEND, 0, 0, 1, 0, 1, '{0, 0, 0, 0, 1, ST_OK}},
      '{CMD_APPEND, P_MAX, P_MAX, 255, 0, 1, '{0, 0, 0, 0, 2, ST_OK}},
      '{CMD_APPEND, P_MID, P_MID, 40, 0, 1, '{0, 0, 0, 0, 3, ST_OK}},
      '{CMD_APPEND, P_NEAR, P_MID, 40, 0, 1, '{0, 0, 0, 0, 4, ST_OK}},
      '{CMD_READ,   0, 0, 0, 0, 1, '{0, 0, 0, 1, 4, ST_OK}},
      '{CMD_READ,   0, 0, 0, 1, 1, '{0, P_MAX, P_MAX, 255, 4, ST_OK}},
      '{CMD_READ,   0, 0, 0, 255, 1, '{0, 0, 0, 0, 4, ST_RANGE}},
      '{CMD_APPEND, P_MID, P_NEAR, 255, 0, 0, '{default: 0}},
      '{CMD_APPEND, P_NEAR, P_NEAR, 20, 0, 0, '{default: 0}},
      '{CMD_APPEND, 7, 7, 7, 0, 1, '{0, 0, 0, 0, 6, ST_FULL}},
      '{CMD_RELAX,  0, 0, 0, 0, 0, '{default: 0}},
      '{CMD_READ,   0, 0, 0, 2, 0, '{default: 0}},
      '{CMD_READ,   0, 0, 0, 3, 0, '{default: 0}},
      '{CMD_DROP,   0, 0, 0, 0, 0, '{default: 0}},
      '{CMD_RELAX,  0, 0, 0, 0, 0, '{default: 0}},
      '{CMD_READ,   0, 0, 0, 0, 0, '{default: 0}},
      '{CMD_CLEAR,  0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_OK}},
      '{CMD_READ,   0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, ST_EMPTY}}
   };

   function automatic logic [POS_W-1:0] rand_pos();
      longint c;
      if ($urandom_range(7) == 0) return POS_W'($urandom);
      c = (cfg_palette << FRAC_BITS) / 2 + $urandom_range(0, 40 << FRAC_BITS)
          - (20 << FRAC_BITS);
      if (c < 0) c = $urandom_range(0, 30 << FRAC_BITS);
      return c[POS_W-1:0];
   endfunction

   function automatic stim_row_type rand_row();
      stim_row_type t;
      int           pick;
      t = '{default: '0};
      pick = $urandom_range(99);
      if (pick < 36) t.cmd = CMD_APPEND;
      else if (pick < 60) t.cmd = CMD_RELAX;
      else if (pick < 80) t.cmd = CMD_READ;
      else if (pick < 90) t.cmd = CMD_DROP;
      else if (pick < 94) t.cmd = CMD_CLEAR;
      else t.cmd = CMD_W'($urandom_range(5, 7));
      t.x = rand_pos();
      t.y = rand_pos();
      t.r = ($urandom_range(9) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(1, 40));
      t.slot = ($urandom_range(4) == 0) ? SLOTIN_W'($urandom)
                                         : SLOTIN_W'($urandom_range(0, m_count + 1));
      return t;
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (empty_tab[n]) send_item(empty_tab[n]);
      drain();
      write_csr(CSR_IN_USE, 6);
      foreach (fill_tab[n]) send_item(fill_tab[n]);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         calm = (ph == 3);
         if (ph == 0) begin
            write_csr(CSR_PALETTE, 1);
            write_csr(CSR_DAMPING, 0);
            write_csr(CSR_NUDGE, 0);
            write_csr(CSR_MODE, 0);
            write_csr(CSR_IN_USE, 3);
         end else if (ph == 1) begin
            write_csr(CSR_PALETTE, 1023);
            write_csr(CSR_DAMPING, 65535);
            write_csr(CSR_NUDGE, 65535);
            write_csr(CSR_MODE, 1);
            write_csr(CSR_IN_USE, 256);
         end else begin
            write_csr(CSR_PALETTE, ($urandom_range(3) == 0) ? 1023 : $urandom_range(1, 1023));
            write_csr(CSR_DAMPING, $urandom_range(0, 65535));
            write_csr(CSR_NUDGE, ($urandom_range(1) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 65535));
            write_csr(CSR_MODE, $urandom_range(1));
            write_csr(CSR_IN_USE, ($urandom_range(7) == 0) ? $urandom_range(0, 511)
                                                           : $urandom_range(0, 12));
         end
         for (int n = 0; n < 9; n++) send_item(rand_row());
         // sender holds off until every result is back
         drain();
      end
      calm = 1'b0;

      drain();
      repeat (20) @(negedge clock);
      if (err_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: disk_overlap_relaxation.f
rtl/core/dor_pkg.sv
rtl/core/dor_ctrl.sv
rtl/core/dor_dp.sv
rtl/core/disk_overlap_relaxation.sv
tb/tb_disk_overlap_relaxation.sv
